// ----- design/pgr_pkg.sv -----
// Shared types and codes for the pan gesture recognizer.
`timescale 1ns / 1ps
package pgr_pkg;

  // Touch event kinds on the input channel.
  typedef enum logic [1:0] {
    ACT_DOWN = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_UP   = 2'd2
  } action_e;

  // Gesture result kinds on the output channel.
  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // Recognizer phase, one-hot.
  typedef enum logic [2:0] {
    PH_READY    = 3'b001,
    PH_POSSIBLE = 3'b010,
    PH_MOVING   = 3'b100
  } phase_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLED   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 8'd1;

  localparam logic [15:0] THRESHOLD_RESET = 16'd16;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         pointer_index;
    logic signed [15:0] touch_x;
    logic signed [15:0] touch_y;
  } item_t;

  typedef struct packed {
    kind_e              event_kind;
    logic               has_coords;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [16:0] delta_x;
    logic signed [16:0] delta_y;
    logic               last;
  } result_t;

  // Results written into the output queue in the same cycle: res0 first, then res1.
  typedef struct packed {
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// ----- design/pgr_result_fifo.sv -----
// Output queue of gesture results, up to two writes and one read per cycle.
`timescale 1ns / 1ps
module pgr_result_fifo
  import pgr_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_1;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  // Keep space for a pan begin plus its move.
  assign room_o  = (count_q <= CntW'(Depth - 2));

  always_comb begin
    wr_ptr_1 = ptr_inc(wr_ptr_q);
    wr_ptr_d = wr_ptr_q;
    case (push_i.n)
      2'd1:    wr_ptr_d = wr_ptr_1;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_1);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_1] <= push_i.res1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> ({1'b0, count_q} + (CntW + 1)'(push_i.n)) <= (CntW + 1)'(Depth))
    else $error("result queue overflow");

endmodule

// ----- design/pan_gesture_recognizer_core.sv -----
// Top level of the pan gesture recognizer: event register, decision logic, result queue.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries touch events: tuser holds the action (down, move, up),
//   tdata the finger index and the x/y coordinates. m_axis carries gesture
//   results: tuser holds the result kind and the has-coordinates flag, tdata
//   the position and the deltas, tlast marks the final result of one event.
//   The cfg channel writes the enable bit (index 0) and the distance
//   threshold (index 1); it is always ready. Write it only while idle.
//   An accepted event waits in the event register until the queue has room;
//   it is then decided and its results go through the result queue to m_axis.
//   Throughput: one event per cycle while the queue has room; one compare of
//   the squared distance against the squared threshold decides each event.
//   A crossing move yields two results (pan begin, then pan move), both
//   written into the queue together.
//   Reset: phase goes to ready, anchor to zero, enable to 1, threshold to 16,
//   result queue empties.
//   Receiver stall: results wait in a small queue; the event register keeps
//   taking events until fewer than two queue slots are free, then holds.
module pan_gesture_recognizer_core
  import pgr_pkg::*;
#(
  parameter int unsigned ResultDepth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: pointer_index[3:0], touch_x[19:4], touch_y[35:20], zero pad[39:36]
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: pos_x[15:0], pos_y[31:16], delta_x[48:32], delta_y[65:49], zero pad[71:66]
  output logic [71:0]          m_axis_tdata,
  // tuser: event_kind[1:0], has_coords[2]
  output logic [2:0]           m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  // Configuration registers.
  logic        enabled_q;
  logic [15:0] threshold_q;

  // Event register.
  logic  item_valid_q, item_valid_d;
  item_t item_q;
  logic  s_accept;

  // Recognizer state.
  phase_e             phase_q, phase_d;
  logic signed [15:0] anchor_x_q, anchor_x_d;
  logic signed [15:0] anchor_y_q, anchor_y_d;

  // Decision datapath.
  logic               room;
  logic               fire;
  logic               primary;
  logic signed [16:0] dx, dy;
  logic [15:0]        abs_dx, abs_dy;
  logic [31:0]        sq_x, sq_y, thr_sq;
  logic [32:0]        dist_sq;
  logic               far;
  push_t              push;
  result_t            q_data;

  // ---------------------------------------------------------------------
  // Configuration: always ready, write by index, ignore unknown indexes.
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b1;
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_IDX_ENABLED) begin
        enabled_q <= cfg_data_i[0];
      end
      if (cfg_index_i == CFG_IDX_THRESHOLD) begin
        threshold_q <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Event register: take a new event when it is empty or the held one is decided now.
  // Ready depends on registers only, so no path runs from m_axis to s_axis.
  // ---------------------------------------------------------------------
  assign fire          = item_valid_q && room;
  assign s_axis_tready = !item_valid_q || room;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_valid_d = item_valid_q;
    if (s_accept) begin
      item_valid_d = 1'b1;
    end else if (fire) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q.action        <= s_axis_tuser;
      item_q.pointer_index <= s_axis_tdata[3:0];
      item_q.touch_x       <= s_axis_tdata[19:4];
      item_q.touch_y       <= s_axis_tdata[35:20];
    end
  end

  // ---------------------------------------------------------------------
  // Distance test: exact squared magnitude against squared threshold.
  // ---------------------------------------------------------------------
  assign primary = (item_q.pointer_index == 4'd0);
  assign dx      = {item_q.touch_x[15], item_q.touch_x} - {anchor_x_q[15], anchor_x_q};
  assign dy      = {item_q.touch_y[15], item_q.touch_y} - {anchor_y_q[15], anchor_y_q};
  // |dx| is at most 65535, so the magnitude fits 16 bits.
  assign abs_dx  = 16'(dx[16] ? -dx : dx);
  assign abs_dy  = 16'(dy[16] ? -dy : dy);
  assign sq_x    = 32'(abs_dx) * 32'(abs_dx);
  assign sq_y    = 32'(abs_dy) * 32'(abs_dy);
  assign thr_sq  = 32'(threshold_q) * 32'(threshold_q);
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign far     = dist_sq > {1'b0, thr_sq};

  // ---------------------------------------------------------------------
  // Decision: next phase, next anchor and the results to queue.
  // ---------------------------------------------------------------------
  always_comb begin
    phase_d    = phase_q;
    anchor_x_d = anchor_x_q;
    anchor_y_d = anchor_y_q;

    push.n               = 2'd0;
    push.res0.event_kind = KIND_MOVE;
    push.res0.has_coords = 1'b1;
    push.res0.pos_x      = item_q.touch_x;
    push.res0.pos_y      = item_q.touch_y;
    push.res0.delta_x    = dx;
    push.res0.delta_y    = dy;
    push.res0.last       = 1'b1;
    push.res1            = push.res0;

    if (fire && enabled_q) begin
      case (item_q.action)
        ACT_DOWN: begin
          if (!primary) begin
            // Second finger: end an active pan without coordinates.
            if (phase_q == PH_MOVING) begin
              push.n               = 2'd1;
              push.res0.event_kind = KIND_END;
              push.res0.has_coords = 1'b0;
              push.res0.pos_x      = '0;
              push.res0.pos_y      = '0;
              push.res0.delta_x    = '0;
              push.res0.delta_y    = '0;
            end
            phase_d = PH_READY;
          end else begin
            // Re-anchor and arm, whatever the phase.
            anchor_x_d = item_q.touch_x;
            anchor_y_d = item_q.touch_y;
            phase_d    = PH_POSSIBLE;
          end
        end
        ACT_MOVE: begin
          if (primary) begin
            case (phase_q)
              PH_POSSIBLE: begin
                if (far) begin
                  // Pan begin at the old anchor, then the first move.
                  push.n               = 2'd2;
                  push.res0.event_kind = KIND_BEGIN;
                  push.res0.pos_x      = anchor_x_q;
                  push.res0.pos_y      = anchor_y_q;
                  push.res0.delta_x    = '0;
                  push.res0.delta_y    = '0;
                  push.res0.last       = 1'b0;
                  push.res1.event_kind = KIND_MOVE;
                  push.res1.pos_x      = item_q.touch_x;
                  push.res1.pos_y      = item_q.touch_y;
                  push.res1.delta_x    = dx;
                  push.res1.delta_y    = dy;
                  push.res1.last       = 1'b1;
                  anchor_x_d           = item_q.touch_x;
                  anchor_y_d           = item_q.touch_y;
                  phase_d              = PH_MOVING;
                end
              end
              PH_MOVING: begin
                // Incremental deltas: advance the anchor on every move.
                push.n     = 2'd1;
                anchor_x_d = item_q.touch_x;
                anchor_y_d = item_q.touch_y;
              end
              default: begin
              end
            endcase
          end
        end
        ACT_UP: begin
          if (primary && (phase_q == PH_MOVING)) begin
            push.n               = 2'd1;
            push.res0.event_kind = KIND_END;
            phase_d              = PH_READY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_READY;
      anchor_x_q <= '0;
      anchor_y_q <= '0;
    end else begin
      phase_q    <= phase_d;
      anchor_x_q <= anchor_x_d;
      anchor_y_q <= anchor_y_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue and output packing.
  // ---------------------------------------------------------------------
  pgr_result_fifo #(
    .Depth (ResultDepth)
  ) u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (q_data)
  );

  assign m_axis_tdata = {6'd0, q_data.delta_y, q_data.delta_x, q_data.pos_y, q_data.pos_x};
  assign m_axis_tuser = {q_data.has_coords, q_data.event_kind};
  assign m_axis_tlast = q_data.last;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_pair_from_possible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n == 2'd2 |-> phase_q == PH_POSSIBLE && phase_d == PH_MOVING)
    else $error("pan begin outside the possible phase");

  a_anchor_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(anchor_x_q) && $stable(anchor_y_q) && $stable(phase_q))
    else $error("state changed without a decided event");

  a_item_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !room |=> item_valid_q && $stable(item_q))
    else $error("held event lost while the queue was full");

  a_disabled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n != 2'd0 |-> enabled_q && fire)
    else $error("result queued while disabled or without an event");

endmodule
